// ----- rtl/apdc_pkg.sv -----
// ----------------------------------------------------------------------------
// apdc_pkg
// Shared constants and the identify-sector table of the ATA PIO disk controller.
// ----------------------------------------------------------------------------
package apdc_pkg;

  localparam int unsigned SECTOR_BYTES     = 512;
  localparam int unsigned DISK_SECTORS_DEF = 256;
  localparam int unsigned USABLE_W         = 17;   // holds up to 65536 sectors

  // task-file register offsets
  localparam logic [3:0] REG_CTL  = 4'd6;
  localparam logic [3:0] REG_DATA = 4'd8;
  localparam logic [3:0] REG_ERR  = 4'd9;
  localparam logic [3:0] REG_CNT  = 4'd10;
  localparam logic [3:0] REG_LBA0 = 4'd11;
  localparam logic [3:0] REG_LBA1 = 4'd12;
  localparam logic [3:0] REG_LBA2 = 4'd13;
  localparam logic [3:0] REG_DEV  = 4'd14;
  localparam logic [3:0] REG_CMD  = 4'd15;

  // commands
  localparam logic [7:0] CMD_READ0  = 8'h20;
  localparam logic [7:0] CMD_READ1  = 8'h21;
  localparam logic [7:0] CMD_WRITE0 = 8'h30;
  localparam logic [7:0] CMD_WRITE1 = 8'h31;
  localparam logic [7:0] CMD_IDENT  = 8'hEC;
  localparam logic [7:0] CMD_NOP0   = 8'h91;
  localparam logic [7:0] CMD_NOP1   = 8'hEF;

  // status / error bits
  localparam logic [7:0] ST_READY = 8'h50;   // DRDY|DSC
  localparam logic [7:0] ST_DRQ_R = 8'h58;   // DRDY|DSC|DRQ
  localparam logic [7:0] ST_FAIL  = 8'h51;   // DRDY|DSC|ERR
  localparam int unsigned ST_DRQ_BIT = 3;
  localparam logic [7:0] ER_IDNF  = 8'h10;
  localparam logic [7:0] ER_ABRT  = 8'h04;
  localparam int unsigned SRST_BIT = 2;

  localparam logic [159:0] ID_SERIAL = "REFDISK000000000001 ";
  localparam logic [63:0]  ID_FW     = "1.0     ";
  localparam logic [319:0] ID_MODEL  = "ATA PIO RAM DISK                        ";

  // One byte of the identify sector. Disk size never reaches one cylinder
  // (16 heads x 63 sectors), so geometry is fixed at one cylinder.
  function automatic logic [7:0] identify_byte(input logic [8:0] pos,
                                               input logic [8:0] nsec);
    logic [15:0] wv;
    int          w;
    int          k;
    wv = 16'h0000;
    w  = int'(pos[8:1]);
    k  = pos[0] ? 0 : 1;
    if (w >= 10 && w < 20) begin
      return ID_SERIAL[(19 - (2 * (w - 10) + k)) * 8 +: 8];
    end
    if (w >= 23 && w < 27) begin
      return ID_FW[(7 - (2 * (w - 23) + k)) * 8 +: 8];
    end
    if (w >= 27 && w < 47) begin
      return ID_MODEL[(39 - (2 * (w - 27) + k)) * 8 +: 8];
    end
    case (w)
      0:       wv = 16'h0040;
      1, 54:   wv = 16'd1;
      3, 55:   wv = 16'd16;
      6, 56:   wv = 16'd63;
      49:      wv = 16'h0200;
      53:      wv = 16'h0001;
      57:      wv = 16'd1008;
      60:      wv = {7'd0, nsec};
      80:      wv = 16'h0006;
      default: wv = 16'h0000;
    endcase
    return pos[0] ? wv[15:8] : wv[7:0];
  endfunction

endpackage

// ----- rtl/ata_pio_disk_controller.sv -----
// ----------------------------------------------------------------------------
// ata_pio_disk_controller
// ATA PIO drive on a byte-wide task-file port with an internal RAM disk.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              word
//  s_axis    in   tvalid/tready          tuser=func, tdata=reg_index,wdata
//  m_axis    out  tvalid/tready          tdata=rdata
//  cfg       in   cfg_we_i (no wait)     cfg_idx_i, cfg_wdata_i
//
//  A register access is answered from the result slot; a data read of a disk
//  sector passes through the StRd state, as the disk RAM read is registered.
//  The data write that completes an in-range sector starts a copy from the
//  sector buffer to the disk RAM, one byte a cycle, input held off meanwhile.
//  Reads of a sector go straight to the disk RAM, so no load pass is needed.
//  Reset clears the task file; the disk RAM keeps no reset state.
//  One result slot: input is taken only when the slot is free or draining.
// ----------------------------------------------------------------------------
module ata_pio_disk_controller #(
  parameter int unsigned DiskSectors = apdc_pkg::DISK_SECTORS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [3:0] reg_index, [11:4] wdata
  input  logic        s_axis_tuser,   // func: 0 read, 1 write
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] rdata
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i
);
  import apdc_pkg::*;

  localparam int unsigned SecW   = (DiskSectors > 1) ? $clog2(DiskSectors) : 1;
  localparam int unsigned DiskAw = SecW + 9;
  localparam int unsigned DiskD  = DiskSectors * SECTOR_BYTES;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRd   = 2'd1;
  localparam logic [1:0] StCopy = 2'd2;

  logic [1:0]  state_q, state_d;
  logic        present_q, present_d;
  logic [8:0]  nsect_q, nsect_d;
  logic [7:0]  status_q, status_d, error_q, error_d, count_q, count_d;
  logic [7:0]  dev_q, dev_d, lastcmd_q, lastcmd_d;
  logic [7:0]  lba0_q, lba0_d, lba1_q, lba1_d, lba2_q, lba2_d;
  logic [9:0]  pos_q, pos_d;
  logic [27:0] lba_q, lba_d;
  logic [8:0]  rem_q, rem_d;
  logic        dir_q, dir_d;
  logic [8:0]  idnsec_q, idnsec_d;      // sector count seen by identify
  logic        ov_q, ov_d;
  logic [7:0]  od_q, od_d;
  logic [27:0] cplba_q, cplba_d;        // sector being flushed
  logic [9:0]  cnt_q, cnt_d;
  logic        pend_q, pend_d;
  logic [8:0]  pidx_q, pidx_d;

  logic [USABLE_W-1:0] usable;
  logic        acc, func;
  logic [3:0]  ridx;
  logic [7:0]  wd;
  logic        drq;
  logic [9:0]  pos_n;
  logic [27:0] lba_n, cmd_lba;
  logic [8:0]  rem_n;

  logic        dk_we, dk_re, bf_we, bf_re;
  logic [DiskAw-1:0] dk_waddr, dk_raddr;
  logic [8:0]  bf_waddr, bf_raddr;
  logic [7:0]  dk_rdata, bf_rdata;

  assign func = s_axis_tuser;
  assign ridx = s_axis_tdata[3:0];
  assign wd   = s_axis_tdata[11:4];
  assign drq  = status_q[ST_DRQ_BIT];

  // usable sectors: min(disk_sectors, DiskSectors), zero without a drive
  always_comb begin
    if (!present_q) begin
      usable = '0;
    end else if ({{(USABLE_W-9){1'b0}}, nsect_q} > USABLE_W'(DiskSectors)) begin
      usable = USABLE_W'(DiskSectors);
    end else begin
      usable = {{(USABLE_W-9){1'b0}}, nsect_q};
    end
  end

  assign s_axis_tready = (state_q == StIdle) && (!ov_q || m_axis_tready);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  assign pos_n   = pos_q + 10'd1;
  assign lba_n   = lba_q + 28'd1;
  assign rem_n   = (rem_q != 9'd0) ? rem_q - 9'd1 : 9'd0;
  assign cmd_lba = {dev_q[3:0], lba2_q, lba1_q, lba0_q};

  assign bf_waddr = pos_q[8:0];
  assign bf_raddr = cnt_q[8:0];
  assign dk_raddr = {lba_q[SecW-1:0], pos_q[8:0]};
  assign dk_waddr = {cplba_q[SecW-1:0], pidx_q};
  assign dk_we    = pend_q;

  always_comb begin
    state_d   = state_q;
    present_d = present_q;
    nsect_d   = nsect_q;
    status_d  = status_q;
    error_d   = error_q;
    count_d   = count_q;
    dev_d     = dev_q;
    lastcmd_d = lastcmd_q;
    lba0_d    = lba0_q;
    lba1_d    = lba1_q;
    lba2_d    = lba2_q;
    pos_d     = pos_q;
    lba_d     = lba_q;
    rem_d     = rem_q;
    dir_d     = dir_q;
    idnsec_d  = idnsec_q;
    ov_d      = ov_q;
    od_d      = od_q;
    cplba_d   = cplba_q;
    cnt_d     = cnt_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    dk_re     = 1'b0;
    bf_we     = 1'b0;
    bf_re     = 1'b0;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      StRd: begin
        od_d    = dk_rdata;
        ov_d    = 1'b1;
        state_d = StIdle;
      end
      StCopy: begin
        if (cnt_q < 10'(SECTOR_BYTES)) begin
          bf_re  = 1'b1;
          pend_d = 1'b1;
          pidx_d = cnt_q[8:0];
          cnt_d  = cnt_q + 10'd1;
        end else begin
          state_d = StIdle;  // last byte lands this cycle
        end
      end
      default: begin
        if (acc) begin
          ov_d = 1'b1;
          od_d = 8'h00;
          if (!func) begin
            unique case (ridx)
              REG_CTL, REG_CMD: od_d = status_q;
              REG_ERR:          od_d = error_q;
              REG_CNT:          od_d = count_q;
              REG_LBA0:         od_d = lba0_q;
              REG_LBA1:         od_d = lba1_q;
              REG_LBA2:         od_d = lba2_q;
              REG_DEV:          od_d = dev_q;
              REG_DATA: begin
                od_d = 8'hFF;
                if (drq && !dir_q && pos_q < 10'(SECTOR_BYTES)) begin
                  if (lastcmd_q == CMD_IDENT) begin
                    od_d = identify_byte(pos_q[8:0], idnsec_q);
                  end else begin
                    dk_re   = 1'b1;
                    ov_d    = 1'b0;
                    state_d = StRd;
                  end
                  pos_d = pos_n;
                  if (pos_n == 10'(SECTOR_BYTES)) begin
                    if (lastcmd_q == CMD_IDENT) begin
                      status_d = ST_READY;
                    end else begin
                      lba_d = lba_n;
                      rem_d = rem_n;
                      if (rem_n != 9'd0 && lba_n < 28'(usable)) begin
                        pos_d = 10'd0;
                      end else begin
                        if (rem_n != 9'd0) error_d = ER_IDNF;
                        status_d = ST_READY;
                      end
                    end
                  end
                end
              end
              default: od_d = 8'hFF;
            endcase
          end else begin
            unique case (ridx)
              REG_CTL: begin
                if (wd[SRST_BIT]) begin
                  status_d  = present_q ? ST_READY : 8'h00;
                  error_d   = 8'h00;
                  count_d   = 8'h00;
                  dev_d     = 8'h00;
                  lastcmd_d = 8'h00;
                  lba0_d    = 8'h00;
                  lba1_d    = 8'h00;
                  lba2_d    = 8'h00;
                  pos_d     = 10'd0;
                  lba_d     = 28'd0;
                  rem_d     = 9'd0;
                  dir_d     = 1'b0;
                end
              end
              REG_DATA: begin
                if (drq && dir_q && pos_q < 10'(SECTOR_BYTES)) begin
                  bf_we = 1'b1;
                  pos_d = pos_n;
                  if (pos_n == 10'(SECTOR_BYTES)) begin
                    if (lba_q < 28'(usable)) begin
                      cplba_d = lba_q;
                      cnt_d   = 10'd0;
                      state_d = StCopy;
                    end else begin
                      error_d  = ER_IDNF;
                      status_d = ST_FAIL;
                    end
                    lba_d = lba_n;
                    rem_d = rem_n;
                    if (rem_n != 9'd0) begin
                      pos_d = 10'd0;
                    end else begin
                      status_d = ST_READY;
                    end
                  end
                end
              end
              REG_CNT:  count_d = wd;
              REG_LBA0: lba0_d  = wd;
              REG_LBA1: lba1_d  = wd;
              REG_LBA2: lba2_d  = wd;
              REG_DEV:  dev_d   = wd;
              REG_CMD: begin
                if (!present_q) begin
                  error_d  = ER_ABRT;
                  status_d = ST_FAIL;
                end else begin
                  lastcmd_d = wd;
                  error_d   = 8'h00;
                  pos_d     = 10'd0;
                  unique case (wd)
                    CMD_NOP0, CMD_NOP1: status_d = ST_READY;
                    CMD_IDENT: begin
                      idnsec_d = usable[8:0];
                      dir_d    = 1'b0;
                      status_d = ST_DRQ_R;
                    end
                    CMD_READ0, CMD_READ1, CMD_WRITE0, CMD_WRITE1: begin
                      lba_d = cmd_lba;
                      rem_d = (count_q != 8'h00) ? {1'b0, count_q} : 9'd256;
                      dir_d = (wd == CMD_WRITE0) || (wd == CMD_WRITE1);
                      if ((wd == CMD_WRITE0) || (wd == CMD_WRITE1)
                          || cmd_lba < 28'(usable)) begin
                        status_d = ST_DRQ_R;
                      end else begin
                        error_d  = ER_IDNF;
                        status_d = ST_FAIL;
                      end
                    end
                    default: begin
                      error_d  = ER_ABRT;
                      status_d = ST_FAIL;
                    end
                  endcase
                end
              end
              default: ;
            endcase
          end
        end
      end
    endcase

    if (cfg_we_i) begin
      if (!cfg_idx_i) begin
        present_d = cfg_wdata_i[0];
        status_d  = cfg_wdata_i[0] ? ST_READY : 8'h00;
      end else begin
        nsect_d = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      present_q <= 1'b0;
      nsect_q   <= '0;
      status_q  <= '0;
      error_q   <= '0;
      count_q   <= '0;
      dev_q     <= '0;
      lastcmd_q <= '0;
      lba0_q    <= '0;
      lba1_q    <= '0;
      lba2_q    <= '0;
      pos_q     <= '0;
      lba_q     <= '0;
      rem_q     <= '0;
      dir_q     <= 1'b0;
      idnsec_q  <= '0;
      ov_q      <= 1'b0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      nsect_q   <= nsect_d;
      status_q  <= status_d;
      error_q   <= error_d;
      count_q   <= count_d;
      dev_q     <= dev_d;
      lastcmd_q <= lastcmd_d;
      lba0_q    <= lba0_d;
      lba1_q    <= lba1_d;
      lba2_q    <= lba2_d;
      pos_q     <= pos_d;
      lba_q     <= lba_d;
      rem_q     <= rem_d;
      dir_q     <= dir_d;
      idnsec_q  <= idnsec_d;
      ov_q      <= ov_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    od_q    <= od_d;
    cplba_q <= cplba_d;
    pidx_q  <= pidx_d;
  end

  // sector buffer: filled by data writes, drained by the flush pass
  apdc_ram #(
    .Depth (SECTOR_BYTES),
    .AddrW (9)
  ) u_sec_buf (
    .clk_i   (clk_i),
    .we_i    (bf_we),
    .waddr_i (bf_waddr),
    .wdata_i (wd),
    .re_i    (bf_re),
    .raddr_i (bf_raddr),
    .rdata_o (bf_rdata)
  );

  // disk store: read directly by data reads, written by the flush pass
  apdc_ram #(
    .Depth (DiskD),
    .AddrW (DiskAw)
  ) u_disk (
    .clk_i   (clk_i),
    .we_i    (dk_we),
    .waddr_i (dk_waddr),
    .wdata_i (bf_rdata),
    .re_i    (dk_re),
    .raddr_i (dk_raddr),
    .rdata_o (dk_rdata)
  );

endmodule

// ----- rtl/apdc_ram.sv -----
// ----------------------------------------------------------------------------
// apdc_ram
// Byte-wide simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module apdc_ram #(
  parameter int unsigned Depth = 512,
  parameter int unsigned AddrW = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
